FILE: src/pilpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PI loop with plant emulation: shared package
// Widths, datapath select codes, the control word and the microprogram.
// ----------------------------------------------------------------------------
package pilpe_pkg;

  // Fixed-point layout: signed Q8.24 values, unsigned Q0.24 time step.
  localparam int FRAC_W   = 24;
  localparam int Q_W      = 32;
  localparam int E_W      = 33;   // error and multiplier A operand
  localparam int MB_W     = 25;   // multiplier B operand
  localparam int P_W      = 58;   // E_W + MB_W
  localparam int ACC_W    = 68;   // holds any exact product sum of a tick
  localparam int RND_W    = 44;   // ACC_W - FRAC_W
  localparam int D_W      = 42;   // plant difference, up to the wide drive
  localparam int U_W      = 42;   // drive
  localparam int SUM_W    = 45;   // state plus rounded increment
  localparam int STEP_W   = 4;
  localparam int UC_STEPS = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [ACC_W-1:0] ACC_HALF = 68'sd8388608;
  localparam logic signed [SUM_W-1:0] Q_MAX_W  = 45'sd2147483647;
  localparam logic signed [SUM_W-1:0] Q_MIN_W  = -45'sd2147483648;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP = 2'd0,
    REG_KI = 2'd1,
    REG_DT = 2'd2
  } reg_idx_t;

  // Multiplier A operand.
  typedef enum logic [2:0] {
    A_E     = 3'd0,
    A_ISUM  = 3'd1,
    A_DFULL = 3'd2,
    A_DLO   = 3'd3,
    A_DHI   = 3'd4
  } a_sel_t;

  // Multiplier B operand.
  typedef enum logic [2:0] {
    B_DT   = 3'd0,
    B_KPLO = 3'd1,
    B_KPHI = 3'd2,
    B_KILO = 3'd3,
    B_KIHI = 3'd4
  } b_sel_t;

  // Accumulator operation on the registered product.
  typedef enum logic [1:0] {
    ACC_HOLD  = 2'd0,
    ACC_LOAD  = 2'd1,
    ACC_ADDSH = 2'd2
  } acc_op_t;

  // Write-back of the rounded accumulator.
  typedef enum logic [2:0] {
    WB_NONE = 3'd0,
    WB_ISUM = 3'd1,
    WB_U    = 3'd2,
    WB_D2   = 3'd3,
    WB_X1   = 3'd4,
    WB_X2   = 3'd5
  } wb_op_t;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    acc_op_t acc_op;
    wb_op_t  wb_op;
    logic    last;
  } ucode_t;

  typedef struct packed {
    logic   start;
    logic   clear;
    ucode_t uc;
  } dp_ctl_t;

  typedef struct packed {
    logic signed [Q_W-1:0] y;
    logic                  sat;
  } dp_res_t;

  localparam ucode_t UC_NOP = '{A_E, B_DT, ACC_HOLD, WB_NONE, 1'b0};

  // Microprogram. A product is formed in the step that selects it, taken
  // into the accumulator one step later and written back the step after.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      4'd0:    w = '{A_E,     B_DT,   ACC_HOLD,  WB_NONE, 1'b0}; // e*dt
      4'd1:    w = '{A_E,     B_KPLO, ACC_LOAD,  WB_NONE, 1'b0}; // Kp low * e
      4'd2:    w = '{A_E,     B_KPHI, ACC_LOAD,  WB_ISUM, 1'b0}; // Kp high * e
      4'd3:    w = '{A_ISUM,  B_KILO, ACC_ADDSH, WB_NONE, 1'b0}; // Ki low * I
      4'd4:    w = '{A_ISUM,  B_KIHI, ACC_LOAD,  WB_U,    1'b0}; // Ki high * I
      4'd5:    w = '{A_DFULL, B_DT,   ACC_ADDSH, WB_NONE, 1'b0}; // d1*dt
      4'd6:    w = '{A_E,     B_DT,   ACC_LOAD,  WB_D2,   1'b0};
      4'd7:    w = '{A_DLO,   B_DT,   ACC_HOLD,  WB_X1,   1'b0}; // d2 low * dt
      4'd8:    w = '{A_DHI,   B_DT,   ACC_LOAD,  WB_NONE, 1'b0}; // d2 high * dt
      4'd9:    w = '{A_E,     B_DT,   ACC_ADDSH, WB_NONE, 1'b0};
      4'd10:   w = '{A_E,     B_DT,   ACC_HOLD,  WB_X2,   1'b1};
      default: w = UC_NOP;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: src/pi_loop_with_plant_emulation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PI loop with plant emulation
// Each item advances a PI controller and a second-order plant by one
// forward-Euler step and returns the plant output from before the step.
// ----------------------------------------------------------------------------
// The 11-step microprogram drives a single shared multiplier through eight
// products per tick; a new item is taken only in idle, once the previous
// tick's program has finished.
// The next item is taken while a finished result waits in the output register.
// Reset clears the loop state to zero and loads the default gains and time step.
module pi_loop_with_plant_emulation
  import pilpe_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Input items.
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [31:0]          s_tdata,   // [31:0] reference
  input  wire logic [0:0]           s_tuser,   // [0] clear
  // Result items.
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [31:0]               m_tdata,   // [31:0] plant_output
  output logic [0:0]                m_tuser,   // [0] saturated
  // Configuration writes.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                state;
  logic [STEP_W-1:0]     step;
  logic signed [Q_W-1:0] proportional_gain;
  logic signed [Q_W-1:0] integral_gain;
  logic [FRAC_W-1:0]     time_step;

  ucode_t                uc;
  logic                  stall;
  logic                  advance_last;
  dp_ctl_t               ctl;
  dp_res_t               res;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      proportional_gain <= 32'sd67108864;
      integral_gain     <= 32'sd50331648;
      time_step         <= 24'd16777;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KP:  proportional_gain <= cfg_data;
        REG_KI:  integral_gain     <= cfg_data;
        REG_DT:  time_step         <= cfg_data[FRAC_W-1:0];
        default: time_step         <= time_step;
      endcase
    end
  end

  // Sequencer: step counter over the microprogram, with a conditional
  // jump back to idle once the output register is free.
  assign uc           = ucode_rom(step);
  assign stall        = uc.last && m_tvalid && !m_tready;
  assign advance_last = (state == ST_RUN) && uc.last && !stall;
  assign s_tready     = (state == ST_IDLE);

  always_comb begin
    ctl.start = s_tvalid && s_tready;
    ctl.clear = s_tuser[0];
    ctl.uc    = ((state == ST_RUN) && !stall) ? uc : UC_NOP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          step <= '0;
          if (s_tvalid && s_tready) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (advance_last) begin
            state <= ST_IDLE;
            step  <= '0;
          end else if (!stall) begin
            step <= step + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
          step  <= '0;
        end
      endcase
    end
  end

  pilpe_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .reference         (s_tdata),
    .proportional_gain (proportional_gain),
    .integral_gain     (integral_gain),
    .time_step         (time_step),
    .res               (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_last) begin
      m_tdata <= res.y;
      m_tuser <= res.sat;
    end
  end

  // Checks on the sequencer.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_RUN && step == '0))
    else $error("item taken without starting the program");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (step < STEP_W'(UC_STEPS)))
    else $error("step counter ran past the program");

  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && stall) |=> (state == ST_RUN && $stable(step)))
    else $error("program left its last step while the output was full");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(advance_last))
    else $error("result offered without the program finishing");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> !s_tready)
    else $error("input taken while a tick is running");

endmodule
`default_nettype wire

FILE: src/pilpe_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PI loop datapath
// One shared 33 x 25 multiplier, a product register, a wide accumulator
// with rounding, and the loop state with saturating write-back.
// ----------------------------------------------------------------------------
module pilpe_datapath
  import pilpe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dp_ctl_t               ctl,
  input  wire logic signed [Q_W-1:0] reference,
  input  wire logic signed [Q_W-1:0] proportional_gain,
  input  wire logic signed [Q_W-1:0] integral_gain,
  input  wire logic [FRAC_W-1:0]     time_step,
  output dp_res_t                    res
);

  logic signed [Q_W-1:0]   isum;
  logic signed [Q_W-1:0]   x1;
  logic signed [Q_W-1:0]   x2;
  logic signed [Q_W-1:0]   y;
  logic signed [E_W-1:0]   e;
  logic signed [D_W-1:0]   d;
  logic signed [U_W-1:0]   u;
  logic signed [P_W-1:0]   p;
  logic signed [ACC_W-1:0] acc;
  logic                    sat;

  logic signed [E_W-1:0]   a_op;
  logic signed [MB_W-1:0]  b_op;
  logic signed [P_W-1:0]   prod;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [RND_W-1:0] rnd;
  logic signed [Q_W-1:0]   st_sel;
  logic signed [SUM_W-1:0] st_sum;
  logic                    st_ovf;
  logic signed [Q_W-1:0]   st_clip;
  logic signed [D_W+3:0]   d2_full;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (ctl.uc.a_sel)
      A_E:     a_op = e;
      A_ISUM:  a_op = {isum[Q_W-1], isum};
      A_DFULL: a_op = d[E_W-1:0];
      A_DLO:   a_op = {{(E_W-FRAC_W){1'b0}}, d[FRAC_W-1:0]};
      A_DHI:   a_op = {{(E_W-D_W+FRAC_W){d[D_W-1]}}, d[D_W-1:FRAC_W]};
      default: a_op = e;
    endcase
    case (ctl.uc.b_sel)
      B_DT:    b_op = {1'b0, time_step};
      B_KPLO:  b_op = {1'b0, proportional_gain[FRAC_W-1:0]};
      B_KPHI:  b_op = {{(MB_W-Q_W+FRAC_W){proportional_gain[Q_W-1]}},
                       proportional_gain[Q_W-1:FRAC_W]};
      B_KILO:  b_op = {1'b0, integral_gain[FRAC_W-1:0]};
      B_KIHI:  b_op = {{(MB_W-Q_W+FRAC_W){integral_gain[Q_W-1]}},
                       integral_gain[Q_W-1:FRAC_W]};
      default: b_op = {1'b0, time_step};
    endcase
  end

  assign prod = a_op * b_op;

  // Round half up: add half an LSB, then drop the fraction bits.
  assign acc_r = acc + ACC_HALF;
  assign rnd   = acc_r[ACC_W-1:FRAC_W];

  // Saturating update of the selected state value.
  always_comb begin
    case (ctl.uc.wb_op)
      WB_ISUM: st_sel = isum;
      WB_X1:   st_sel = x1;
      WB_X2:   st_sel = x2;
      default: st_sel = isum;
    endcase
    st_sum = {{(SUM_W-Q_W){st_sel[Q_W-1]}}, st_sel} + {rnd[RND_W-1], rnd};
    st_ovf = 1'b0;
    st_clip = st_sum[Q_W-1:0];
    if (st_sum > Q_MAX_W) begin
      st_ovf  = 1'b1;
      st_clip = Q_MAX_W[Q_W-1:0];
    end else if (st_sum < Q_MIN_W) begin
      st_ovf  = 1'b1;
      st_clip = Q_MIN_W[Q_W-1:0];
    end
  end

  // Drive minus the old second plant state.
  assign d2_full = {{4{u[U_W-1]}}, u} + {{(D_W+4-RND_W){rnd[RND_W-1]}}, rnd}
                 - {{(D_W+4-Q_W){x2[Q_W-1]}}, x2};

  // Product register and accumulator.
  always_ff @(posedge clk) begin
    p <= prod;
    case (ctl.uc.acc_op)
      ACC_LOAD:  acc <= {{(ACC_W-P_W){p[P_W-1]}}, p};
      ACC_ADDSH: acc <= acc + {p[ACC_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
      default:   acc <= acc;
    endcase
  end

  // Per-tick operands, captured when an item is taken or written back by the program.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      if (ctl.clear) begin
        y <= '0;
        e <= {reference[Q_W-1], reference};
        d <= '0;
      end else begin
        y <= x1;
        e <= {reference[Q_W-1], reference} - {x1[Q_W-1], x1};
        d <= {{(D_W-E_W){1'b0}}, {(E_W){1'b0}}}
             + {{(D_W-Q_W){x2[Q_W-1]}}, x2} - {{(D_W-Q_W){x1[Q_W-1]}}, x1};
      end
    end else if (ctl.uc.wb_op == WB_D2) begin
      d <= d2_full[D_W-1:0];
    end
    if (ctl.uc.wb_op == WB_U) begin
      u <= rnd[U_W-1:0];
    end
  end

  // Loop state and the saturation flag of the running tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      isum <= '0;
      x1   <= '0;
      x2   <= '0;
      sat  <= 1'b0;
    end else if (ctl.start) begin
      sat <= 1'b0;
      if (ctl.clear) begin
        isum <= '0;
        x1   <= '0;
        x2   <= '0;
      end
    end else begin
      case (ctl.uc.wb_op)
        WB_ISUM: begin
          isum <= st_clip;
          sat  <= sat | st_ovf;
        end
        WB_X1: begin
          x1  <= st_clip;
          sat <= sat | st_ovf;
        end
        WB_X2: begin
          x2  <= st_clip;
          sat <= sat | st_ovf;
        end
        default: sat <= sat;
      endcase
    end
  end

  // The flag includes a clip in the step that ends the program.
  always_comb begin
    res.y   = y;
    res.sat = sat | (((ctl.uc.wb_op == WB_ISUM) || (ctl.uc.wb_op == WB_X1) ||
                      (ctl.uc.wb_op == WB_X2)) && st_ovf);
  end

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the PI loop with plant emulation
// Each item sent to the block is also applied to a fixed-point model of the
// loop held in a scoreboard. Each returned item is checked against the
// oldest expected one. Gains and time step are changed between phases, once
// the block has gone quiet. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import pilpe_pkg::*;

  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASES        = 14;
  localparam int PHASE_ITEMS   = 112;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic [31:0] KP_DEFAULT = 32'h0400_0000;
  localparam logic [31:0] KI_DEFAULT = 32'h0300_0000;
  localparam logic [23:0] DT_DEFAULT = 24'd16777;
  localparam logic [31:0] Q_TOP      = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_BOTTOM   = 32'h8000_0000;
  localparam logic [31:0] Q_ONE      = 32'h0100_0000;

  typedef logic signed [127:0] wide_t;

  localparam wide_t HALF_LSB = 128'sd8388608;
  localparam wide_t Q_HI     = 128'sd2147483647;
  localparam wide_t Q_LO     = -128'sd2147483648;

  typedef struct packed {
    logic [31:0] plant_output;
    logic        saturated;
  } tick_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: loop state, gains and the ticks still waiting for a result.
  // --------------------------------------------------------------------------
  class loop_scoreboard;
    logic signed [31:0] kp, ki, isum, x1, x2;
    logic [23:0]        dt;
    bit                 clipped;
    int                 failures;
    tick_result_t       awaited[$];

    function new();
      kp = KP_DEFAULT;
      ki = KI_DEFAULT;
      dt = DT_DEFAULT;
      isum = '0;
      x1 = '0;
      x2 = '0;
      failures = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_KP: kp = value;
        REG_KI: ki = value;
        REG_DT: dt = value[23:0];
        default: ;
      endcase
    endfunction

    // Divide by 2^24, rounding half up.
    function wide_t scale_q24(wide_t v);
      return (v + HALF_LSB) >>> 24;
    endfunction

    // Clip to the Q8.24 range and remember that a limit was hit.
    function logic signed [31:0] clamp_q(wide_t v);
      if (v > Q_HI) begin
        clipped = 1'b1;
        return Q_TOP;
      end
      if (v < Q_LO) begin
        clipped = 1'b1;
        return Q_BOTTOM;
      end
      return v[31:0];
    endfunction

    // One forward-Euler tick of the closed loop for an accepted item.
    function void note_tick(logic [31:0] setpoint_bits, logic clr);
      wide_t              err, dtw, iw, drive, x1w, x2w, kpw, kiw;
      logic signed [31:0] sp, isum_next, x1_next, x2_next;
      tick_result_t       res;
      if (clr) begin
        isum = '0;
        x1 = '0;
        x2 = '0;
      end
      clipped = 1'b0;
      sp = setpoint_bits;
      dtw = dt;
      kpw = kp;
      kiw = ki;
      x1w = x1;
      x2w = x2;
      err = sp;
      err = err - x1w;
      iw = isum;
      isum_next = clamp_q(iw + scale_q24(err * dtw));
      iw = isum_next;
      // The drive stays at full width; only the states are clipped.
      drive = scale_q24(kpw * err) + scale_q24(kiw * iw);
      x1_next = clamp_q(x1w + scale_q24((x2w - x1w) * dtw));
      x2_next = clamp_q(x2w + scale_q24((drive - x2w) * dtw));
      res.plant_output = x1;
      res.saturated = clipped;
      awaited = {awaited, res};
      isum = isum_next;
      x1 = x1_next;
      x2 = x2_next;
    endfunction

    function void check_result(logic [31:0] data, logic sat);
      tick_result_t want;
      if (awaited.size() == 0) begin
        $error("result item with no tick outstanding: plant_output %h", data);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (data !== want.plant_output) begin
        $error("plant_output: expected %h, actual %h", want.plant_output, data);
        failures++;
      end
      if (sat !== want.saturated) begin
        $error("saturated: expected %b, actual %b", want.saturated, sat);
        failures++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;
  logic [0:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;
  logic [0:0]           m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KP;
  logic [31:0]          cfg_data = '0;

  logic                 calm = 1'b0;
  int                   stuck;
  loop_scoreboard       sb;

  pi_loop_with_plant_emulation DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Result side stalls at random except in the calm phase.
  always @(posedge clk) begin
    if (rst || calm) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 10);
    end
  end

  // Handshake monitor: values seen here are those from before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_register(cfg_index, cfg_data);
      end
      if (s_tvalid && s_tready) begin
        sb.note_tick(s_tdata, s_tuser[0]);
      end
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata, m_tuser[0]);
      end
    end
  end

  // Watchdog: ends the run after too long without any handshake.
  initial begin
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  // Offer one item and hold it until taken; tvalid is left high.
  task automatic push_item(input logic [31:0] setpoint, input logic clr);
    while (!calm && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= setpoint;
    s_tuser <= clr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // One register write; cfg_valid is left high for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    while (!calm && $urandom_range(99) < 10) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Upper bits of the time step write are junk and must be ignored.
  task automatic load_gains(input logic [31:0] kp, input logic [31:0] ki,
                            input logic [23:0] dt);
    logic [7:0] pad;
    pad = 8'($urandom_range(255));
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    if ($urandom_range(1)) write_reg(REG_SPARE, $urandom);
    write_reg(REG_DT, {pad, dt});
    cfg_valid <= 1'b0;
  endtask

  // Stop offering items and wait until every expected result is back.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_setpoint();
    logic signed [31:0] v;
    v = $urandom;
    case ($urandom_range(7))
      0: return $urandom_range(1) ? Q_TOP : Q_BOTTOM;
      1, 2: return v;
      default: return v >>> $urandom_range(3, 12);
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    logic signed [31:0] v;
    v = $urandom;
    case ($urandom_range(3))
      0: return $urandom_range(1) ? Q_TOP : Q_BOTTOM;
      1: return v;
      default: return v >>> $urandom_range(3, 9);
    endcase
  endfunction

  // Gains and step for a phase: defaults, moderate, mixed random, extremes.
  task automatic pick_phase_gains(input int phase);
    logic [31:0] kp, ki;
    logic [23:0] dt;
    case (phase % 4)
      0: begin
        kp = KP_DEFAULT;
        ki = KI_DEFAULT;
        dt = DT_DEFAULT;
      end
      1: begin
        kp = $signed($urandom) >>> $urandom_range(4, 9);
        ki = $signed($urandom) >>> $urandom_range(4, 9);
        dt = 24'($urandom_range(1, 24'h40_0000));
      end
      2: begin
        kp = pick_gain();
        ki = pick_gain();
        dt = 24'($urandom_range(0, 24'hFF_FFFF));
      end
      default: begin
        kp = $urandom_range(1) ? Q_TOP : Q_BOTTOM;
        ki = $urandom_range(2) == 0 ? 32'h0 : ($urandom_range(1) ? Q_TOP : Q_BOTTOM);
        dt = $urandom_range(1) ? 24'hFF_FFFF : 24'h0;
      end
    endcase
    load_gains(kp, ki, dt);
  endtask

  // A step response: usually starts from a cleared loop, holds the setpoint
  // with the odd change along the way.
  task automatic run_step_sequence(inout int sent);
    int          len;
    logic [31:0] sp;
    len = $urandom_range(8, 48);
    sp = pick_setpoint();
    push_item(sp, $urandom_range(9) != 0);
    sent++;
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(9) == 0) sp = pick_setpoint();
      push_item(sp, 1'b0);
      sent++;
    end
  endtask

  // Directed ticks: range limits, clear, saturation and the spare index.
  task automatic run_directed();
    push_item(Q_TOP, 1'b1);
    push_item(Q_TOP, 1'b0);
    push_item(Q_BOTTOM, 1'b0);
    push_item(32'h0, 1'b0);
    push_item(Q_ONE, 1'b1);
    push_item(Q_ONE, 1'b0);
    push_item(Q_ONE, 1'b0);
    drain();
    // Largest gains and a unit step drive the states into their limits.
    load_gains(Q_TOP, Q_BOTTOM, 24'hFF_FFFF);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    push_item(Q_TOP, 1'b1);
    for (int i = 0; i < 6; i++) push_item(i[0] ? Q_BOTTOM : Q_TOP, 1'b0);
    push_item(Q_BOTTOM, 1'b1);
    push_item(Q_BOTTOM, 1'b0);
    push_item(Q_BOTTOM, 1'b0);
    drain();
    // Zero step: the loop must not move at all.
    load_gains(Q_BOTTOM, Q_TOP, 24'h0);
    push_item(Q_TOP, 1'b0);
    push_item(Q_BOTTOM, 1'b0);
    push_item(Q_ONE, 1'b1);
    drain();
    load_gains(32'h0, 32'h0, 24'hFF_FFFF);
    push_item(Q_ONE, 1'b1);
    push_item(Q_TOP, 1'b0);
    push_item(Q_BOTTOM, 1'b0);
    drain();
  endtask

  // Main sequence.
  initial begin
    int sent;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int phase = 0; phase < PHASES; phase++) begin
      calm <= (phase == 6);
      pick_phase_gains(phase);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(3) == 0) begin
          // Noise: unrelated setpoints and random clears.
          repeat ($urandom_range(1, 6)) begin
            push_item($urandom, $urandom_range(3) == 0);
            sent++;
          end
        end else begin
          run_step_sequence(sent);
        end
      end
      drain();
    end
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: pi_loop_with_plant_emulation.f
src/pilpe_pkg.sv
src/pilpe_datapath.sv
src/pi_loop_with_plant_emulation.sv
sim/tb_top.sv
